@@ sv/extended_euclid_gcd_macros.svh @@
// Assertion macros for the checker file.
`ifndef EXTENDED_EUCLID_GCD_MACROS_SVH
`define EXTENDED_EUCLID_GCD_MACROS_SVH

// Same-cycle implication.
`define EEG_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("eeg checker: same-cycle property failed");

// Next-cycle implication.
`define EEG_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("eeg checker: next-cycle property failed");

`endif

@@ sv/eeg_pkg.sv @@
// Shared types for the extended Euclid gcd block.
`default_nettype none
package eeg_pkg;

   typedef enum logic [1:0] {
      OP_PROBE,
      OP_REDUCE,
      OP_UPDATE
   } eeg_op_type;

   typedef struct packed {
      logic ge;
      logic rem_zero;
   } eeg_stat_type;

endpackage
`default_nettype wire

@@ sv/eeg_alu.sv @@
// Shared compare/subtract unit and coefficient adders of the gcd sequencer.
`default_nettype none
module eeg_alu
   import eeg_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input  wire eeg_op_type       op,
   input  wire [WIDTH-2:0]       rem,
   input  wire [WIDTH-2:0]       dvs,
   input  wire [WIDTH-1:0]       xc,
   input  wire [WIDTH-1:0]       yc,
   input  wire [WIDTH-1:0]       px,
   input  wire [WIDTH-1:0]       py,
   input  wire [WIDTH-1:0]       xp,
   input  wire [WIDTH-1:0]       yp,
   output eeg_stat_type          stat,
   output logic [WIDTH-2:0]      rem_out,
   output logic [WIDTH-1:0]      cx_out,
   output logic [WIDTH-1:0]      cy_out
);

   localparam int VW = WIDTH - 1;

   logic [VW:0]      opb;
   logic [VW+1:0]    diff;
   logic [WIDTH-1:0] ax, bx, ay, by;
   logic             cin;

   always_comb begin
      opb           = (op == OP_PROBE) ? {dvs, 1'b0} : {1'b0, dvs};
      diff          = {2'b00, rem} - {1'b0, opb};
      stat.ge       = ~diff[VW+1];
      stat.rem_zero = (rem == '0);
      rem_out       = stat.ge ? diff[VW-1:0] : rem;
   end

   // Horner accumulation of q*coef during reduce; x_prev - q*x_cur on update.
   always_comb begin
      case (op)
         OP_UPDATE: begin
            ax  = xp;
            bx  = ~px;
            ay  = yp;
            by  = ~py;
            cin = 1'b1;
         end
         default: begin
            ax  = {px[WIDTH-2:0], 1'b0};
            bx  = stat.ge ? xc : '0;
            ay  = {py[WIDTH-2:0], 1'b0};
            by  = stat.ge ? yc : '0;
            cin = 1'b0;
         end
      endcase
      cx_out = ax + bx + WIDTH'(cin);
      cy_out = ay + by + WIDTH'(cin);
   end

endmodule
`default_nettype wire

@@ sv/extended_euclid_gcd.sv @@
// Top level: extended Euclid gcd with Bezout coefficients, one shared unit.
//
//  channel | dir | handshake            | payload
//  req     | in  | req_tvalid/tready    | first_value, second_value
//  rsp     | out | rsp_tvalid/tready    | gcd_value, coef_first, coef_second
//
// Per division step: probe states shift the divisor left to align it, reduce
// states develop the quotient one bit at a time, and an update state follows.
// The single compare/subtract unit in eeg_alu sets the pace.
// Synchronous active-high reset clears the sequencer and the output valid.
// A waiting result sits in the output register and holds the sequencer in its
// finish state; a new transaction is taken only when the sequencer is idle.
`default_nettype none
module extended_euclid_gcd
   import eeg_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_tvalid,
   output logic                                 req_tready,
   // first_value, second_value; zero fill to bytes
   input  wire [((2*(WIDTH-1)+7)/8)*8-1:0]      req_tdata,
   output logic                                 rsp_tvalid,
   input  wire                                  rsp_tready,
   // gcd_value, coef_first, coef_second; zero fill to bytes
   output logic [((3*WIDTH-1+7)/8)*8-1:0]       rsp_tdata
);

   localparam int VW    = WIDTH - 1;
   localparam int KW    = $clog2(VW);
   localparam int RSP_W = ((3*WIDTH-1+7)/8)*8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PROBE,
      ST_REDUCE,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   state_type        state_ff, state_in;
   logic [VW-1:0]    rp_ff, rp_in, rc_ff, rc_in, rem_ff, rem_in, d_ff, d_in;
   logic [WIDTH-1:0] xp_ff, xp_in, xc_ff, xc_in, yp_ff, yp_in, yc_ff, yc_in;
   logic [WIDTH-1:0] px_ff, px_in, py_ff, py_in;
   logic [KW-1:0]    k_ff, k_in;
   logic [VW-1:0]    gcd_ff, gcd_in;
   logic [WIDTH-1:0] cf_ff, cf_in, cs_ff, cs_in;
   logic             rsp_valid_ff, rsp_valid_in;

   eeg_op_type       op;
   eeg_stat_type     stat;
   logic [VW-1:0]    alu_rem;
   logic [WIDTH-1:0] alu_cx, alu_cy;
   logic [VW-1:0]    first_value, second_value;
   logic             out_free;

   assign first_value  = req_tdata[VW-1:0];
   assign second_value = req_tdata[2*VW-1:VW];

   eeg_alu #(.WIDTH(WIDTH)) u_alu (
      .op      (op),
      .rem     (rem_ff),
      .dvs     (d_ff),
      .xc      (xc_ff),
      .yc      (yc_ff),
      .px      (px_ff),
      .py      (py_ff),
      .xp      (xp_ff),
      .yp      (yp_ff),
      .stat    (stat),
      .rem_out (alu_rem),
      .cx_out  (alu_cx),
      .cy_out  (alu_cy)
   );

   always_comb begin
      case (state_ff)
         ST_REDUCE: op = OP_REDUCE;
         ST_UPDATE: op = OP_UPDATE;
         default:   op = OP_PROBE;
      endcase
   end

   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      rp_in        = rp_ff;
      rc_in        = rc_ff;
      rem_in       = rem_ff;
      d_in         = d_ff;
      xp_in        = xp_ff;
      xc_in        = xc_ff;
      yp_in        = yp_ff;
      yc_in        = yc_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      k_in         = k_ff;
      gcd_in       = gcd_ff;
      cf_in        = cf_ff;
      cs_in        = cs_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               rp_in  = first_value;
               rc_in  = second_value;
               rem_in = first_value;
               d_in   = second_value;
               xp_in  = WIDTH'(1);
               xc_in  = '0;
               yp_in  = '0;
               yc_in  = WIDTH'(1);
               px_in  = '0;
               py_in  = '0;
               k_in   = '0;
               state_in = (second_value == '0) ? ST_FINISH : ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (stat.ge) begin
               d_in = {d_ff[VW-2:0], 1'b0};
               k_in = k_ff + KW'(1);
            end else begin
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            rem_in = alu_rem;
            px_in  = alu_cx;
            py_in  = alu_cy;
            if (k_ff == '0) begin
               state_in = ST_UPDATE;
            end else begin
               d_in = {1'b0, d_ff[VW-1:1]};
               k_in = k_ff - KW'(1);
            end
         end
         ST_UPDATE: begin
            rp_in = rc_ff;
            rc_in = rem_ff;
            xp_in = xc_ff;
            xc_in = alu_cx;
            yp_in = yc_ff;
            yc_in = alu_cy;
            if (stat.rem_zero) begin
               state_in = ST_FINISH;
            end else begin
               d_in     = rem_ff;
               rem_in   = rc_ff;
               k_in     = '0;
               px_in    = '0;
               py_in    = '0;
               state_in = ST_PROBE;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               gcd_in       = rp_ff;
               cf_in        = xp_ff;
               cs_in        = yp_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rp_ff  <= rp_in;
      rc_ff  <= rc_in;
      rem_ff <= rem_in;
      d_ff   <= d_in;
      xp_ff  <= xp_in;
      xc_ff  <= xc_in;
      yp_ff  <= yp_in;
      yc_ff  <= yc_in;
      px_ff  <= px_in;
      py_ff  <= py_in;
      k_ff   <= k_in;
      gcd_ff <= gcd_in;
      cf_ff  <= cf_in;
      cs_ff  <= cs_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({cs_ff, cf_ff, gcd_ff});

endmodule
`default_nettype wire

@@ sv/eeg_checker.sv @@
// Port-level checker for the extended Euclid gcd block, bound to the top level.
`default_nettype none
`include "extended_euclid_gcd_macros.svh"
module eeg_checker #(
   parameter int WIDTH = 32
) (
   input wire                               clock,
   input wire                               reset,
   input wire                               req_tvalid,
   input wire                               req_tready,
   input wire                               rsp_tvalid,
   input wire                               rsp_tready,
   input wire [((3*WIDTH-1+7)/8)*8-1:0]     rsp_tdata
);

   logic req_fire;
   assign req_fire = req_tvalid & req_tready;

   // stalled result holds
   `EEG_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   // one transaction at a time: busy after an accept
   `EEG_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_fire, !req_tready)
   // a new result only appears after the sequencer was busy
   `EEG_ASSERT_NOW(a_rsp_from_work, clock, reset, $rose(rsp_tvalid), !$past(req_tready))

endmodule

bind extended_euclid_gcd eeg_checker #(.WIDTH(WIDTH)) u_eeg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
